// ----- design/tidx_pkg.sv -----
// Shared constants, types and helpers for the tensor index linearizer.
`timescale 1ns / 1ps

package tidx_pkg;

	localparam int NDIM       = 4;
	localparam int MAX_RANK   = 4;
	localparam int COORD_BITS = 8;

	localparam int OFF_W      = 32;
	localparam int TOT_W      = OFF_W + 1;
	localparam int COORD_W    = 8;
	localparam int DIM_W      = 9;
	localparam int RANK_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// Quotient bits resolved per inner dimension: an extent never exceeds 256.
	localparam int QI_W  = 8;
	// Dimension 0 resolves a full offset; dimensions 1 and 2 one byte each;
	// the last dimension is taken from the final remainder.
	localparam int NCELL = OFF_W + (NDIM - 2) * QI_W;

	localparam logic [RANK_W-1:0] RANK_LIM =
		RANK_W'((MAX_RANK < NDIM) ? MAX_RANK : NDIM);
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(256);
	localparam logic [COORD_W-1:0] COORD_MASK =
		(COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANK = 3'd0,
		REG_DIM0 = 3'd1,
		REG_DIM1 = 3'd2,
		REG_DIM2 = 3'd3,
		REG_DIM3 = 3'd4
	} reg_idx_t;

	typedef enum logic {
		REQ_LIN   = 1'b0,
		REQ_DELIN = 1'b1
	} req_kind_t;

	// Derived configuration seen by the datapath.
	typedef struct packed {
		logic                             busy;
		logic [RANK_W-1:0]                rank;
		logic [NDIM-2:0][OFF_W-1:0]       stride;
		logic [TOT_W-1:0]                 total;
	} cfg_t;

	// Word carried down the cell chain.
	typedef struct packed {
		logic                             delin;
		logic                             oor;
		logic [OFF_W-1:0]                 rem;
		logic [TOT_W-1:0]                 acc;
		logic [NDIM-1:0][COORD_W-1:0]     coord;
	} stage_t;

	typedef struct packed {
		logic [OFF_W-1:0]                 offset;
		logic [NDIM-1:0][COORD_W-1:0]     coord;
		logic                             oor;
	} rsp_t;

	function automatic logic [COORD_W-1:0] mask_coord(input logic [COORD_W-1:0] v);
		return v & COORD_MASK;
	endfunction

endpackage

// ----- design/tidx_req_if.sv -----
// Request channel: coordinates or an offset to convert.
`timescale 1ns / 1ps

interface tidx_req_if import tidx_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [COORD_W-1:0] coord0_in;
	logic [COORD_W-1:0] coord1_in;
	logic [COORD_W-1:0] coord2_in;
	logic [COORD_W-1:0] coord3_in;
	logic [OFF_W-1:0]   offset_in;

	modport source (
		output valid, req_type, coord0_in, coord1_in, coord2_in, coord3_in, offset_in,
		input  ready
	);
	modport sink (
		input  valid, req_type, coord0_in, coord1_in, coord2_in, coord3_in, offset_in,
		output ready
	);
endinterface

// ----- design/tidx_rsp_if.sv -----
// Response channel: linear offset or coordinates with the range flag.
`timescale 1ns / 1ps

interface tidx_rsp_if import tidx_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OFF_W-1:0]   offset_out;
	logic [COORD_W-1:0] coord0_out;
	logic [COORD_W-1:0] coord1_out;
	logic [COORD_W-1:0] coord2_out;
	logic [COORD_W-1:0] coord3_out;
	logic               out_of_range;

	modport source (
		output valid, offset_out, coord0_out, coord1_out, coord2_out, coord3_out,
		       out_of_range,
		input  ready
	);
	modport sink (
		input  valid, offset_out, coord0_out, coord1_out, coord2_out, coord3_out,
		       out_of_range,
		output ready
	);
endinterface

// ----- design/tensor_index_linearizer.sv -----
// Top level of the row-major tensor index linearizer and delinearizer.
// Throughput: one word per cycle unless the output stalls or a stride rebuild runs; the
// 48-cell chain resolves one bit or adds one stride term per cell. A write to a used
// configuration register holds req.ready low while one shared multiplier rebuilds the
// strides and the total size; reset gives rank 1, extents 1 and an empty chain.
`timescale 1ns / 1ps

module tensor_index_linearizer import tidx_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	tidx_req_if.sink              req,
	tidx_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                         cfg;
	logic                         en;
	logic                         stall;
	logic                         accept;
	logic [NDIM-1:0][COORD_W-1:0] coord_in;
	stage_t                       entry_d;
	stage_t                       entry_s1;
	logic                         entry_vld_s1;
	logic [NCELL:0]               vld_c;
	stage_t                       stage_c [NCELL+1];
	logic                         res_vld;
	rsp_t                         res;

	tidx_stride_gen u_stride_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign en        = !stall;
	assign req.ready = en && !cfg.busy;
	assign accept    = req.valid && req.ready;

	assign coord_in[0] = req.coord0_in;
	assign coord_in[1] = req.coord1_in;
	assign coord_in[2] = req.coord2_in;
	assign coord_in[3] = req.coord3_in;

	always_comb begin
		entry_d       = '0;
		entry_d.delin = (req.req_type == REQ_DELIN);
		if (entry_d.delin) begin
			entry_d.rem = req.offset_in;
			entry_d.oor = ({1'b0, req.offset_in} >= cfg.total);
		end else begin
			// Coordinates past the rank are dropped here.
			for (int j = 0; j < NDIM; j++) begin
				if (RANK_W'(j) < cfg.rank) begin
					entry_d.coord[j] = mask_coord(coord_in[j]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_s1 <= 1'b0;
		end else if (en) begin
			entry_vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			entry_s1 <= entry_d;
		end
	end

	assign vld_c[0]   = entry_vld_s1;
	assign stage_c[0] = entry_s1;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		localparam int CDIM   = (i < OFF_W) ? 0 : 1 + (i - OFF_W) / QI_W;
		localparam int CSHIFT = (i < OFF_W) ? OFF_W - 1 - i : QI_W - 1 - ((i - OFF_W) % QI_W);

		tidx_cell #(
			.DIM   (CDIM),
			.SHIFT (CSHIFT)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_vld    (vld_c[i]),
			.in_stage  (stage_c[i]),
			.divisor   (cfg.stride[CDIM]),
			.out_vld   (vld_c[i+1]),
			.out_stage (stage_c[i+1])
		);
	end

	tidx_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.tail_vld  (vld_c[NCELL]),
		.tail      (stage_c[NCELL]),
		.total     (cfg.total),
		.out_ready (rsp.ready),
		.out_vld   (res_vld),
		.res       (res),
		.stall     (stall)
	);

	assign rsp.valid        = res_vld;
	assign rsp.offset_out   = res.offset;
	assign rsp.coord0_out   = res.coord[0];
	assign rsp.coord1_out   = res.coord[1];
	assign rsp.coord2_out   = res.coord[2];
	assign rsp.coord3_out   = res.coord[3];
	assign rsp.out_of_range = res.oor;

endmodule

// ----- design/tidx_stride_gen.sv -----
// Configuration registers and the stride and total-size recompute sequencer.
`timescale 1ns / 1ps

module tidx_stride_gen import tidx_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	typedef enum logic [4:0] {
		RC_IDLE = 5'b00001,
		RC_S2   = 5'b00010,
		RC_S1   = 5'b00100,
		RC_S0   = 5'b01000,
		RC_TOT  = 5'b10000
	} rc_state_t;

	rc_state_t                      state_q;
	logic [RANK_W-1:0]              rank_q;
	logic [NDIM-1:0][DIM_W-1:0]     dim_q;
	logic [NDIM-2:0][OFF_W-1:0]     stride_q;
	logic [TOT_W-1:0]               total_q;

	logic [RANK_W-1:0]              eff_rank;
	logic [NDIM-1:0][DIM_W-1:0]     ext;
	logic [DIM_W-1:0]               mul_a;
	logic [OFF_W-1:0]               mul_b;
	logic [DIM_W+OFF_W-1:0]         prod;
	logic                           cfg_hit;

	assign cfg_hit = cfg_we && (cfg_index <= REG_DIM3);

	always_comb begin
		if (rank_q == '0) begin
			eff_rank = RANK_W'(1);
		end else if (rank_q > RANK_LIM) begin
			eff_rank = RANK_LIM;
		end else begin
			eff_rank = rank_q;
		end
	end

	// Extents beyond the rank count as one, so every stride is a suffix product.
	always_comb begin
		for (int j = 0; j < NDIM; j++) begin
			if (RANK_W'(j) >= eff_rank) begin
				ext[j] = DIM_W'(1);
			end else if (dim_q[j] == '0) begin
				ext[j] = DIM_W'(1);
			end else if (dim_q[j] > DIM_MAX) begin
				ext[j] = DIM_MAX;
			end else begin
				ext[j] = dim_q[j];
			end
		end
	end

	always_comb begin
		unique case (state_q)
			RC_S2: begin
				mul_a = ext[3];
				mul_b = OFF_W'(1);
			end
			RC_S1: begin
				mul_a = ext[2];
				mul_b = stride_q[2];
			end
			RC_S0: begin
				mul_a = ext[1];
				mul_b = stride_q[1];
			end
			RC_TOT: begin
				mul_a = ext[0];
				mul_b = stride_q[0];
			end
			default: begin
				mul_a = ext[0];
				mul_b = stride_q[0];
			end
		endcase
		prod = (DIM_W+OFF_W)'(mul_a) * (DIM_W+OFF_W)'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= RC_IDLE;
			rank_q   <= RANK_W'(1);
			dim_q    <= {NDIM{DIM_W'(1)}};
			stride_q <= {(NDIM-1){OFF_W'(1)}};
			total_q  <= TOT_W'(1);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RANK: rank_q   <= cfg_data[RANK_W-1:0];
					REG_DIM0: dim_q[0] <= cfg_data;
					REG_DIM1: dim_q[1] <= cfg_data;
					REG_DIM2: dim_q[2] <= cfg_data;
					REG_DIM3: dim_q[3] <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				RC_S2:   stride_q[2] <= prod[OFF_W-1:0];
				RC_S1:   stride_q[1] <= prod[OFF_W-1:0];
				RC_S0:   stride_q[0] <= prod[OFF_W-1:0];
				RC_TOT:  total_q     <= prod[TOT_W-1:0];
				default: ;
			endcase
			// A new write to a used register restarts the walk from the innermost dimension.
			if (cfg_hit) begin
				state_q <= RC_S2;
			end else begin
				unique case (state_q)
					RC_S2:   state_q <= RC_S1;
					RC_S1:   state_q <= RC_S0;
					RC_S0:   state_q <= RC_TOT;
					RC_TOT:  state_q <= RC_IDLE;
					default: state_q <= RC_IDLE;
				endcase
			end
		end
	end

	assign cfg.busy   = (state_q != RC_IDLE);
	assign cfg.rank   = eff_rank;
	assign cfg.stride = stride_q;
	assign cfg.total  = total_q;

endmodule

// ----- design/tidx_cell.sv -----
// One chain cell: resolves one quotient bit or adds one shifted stride term.
`timescale 1ns / 1ps

module tidx_cell import tidx_pkg::*; #(
	parameter int DIM   = 0,
	parameter int SHIFT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  stage_t           in_stage,
	input  logic [OFF_W-1:0] divisor,
	output logic             out_vld,
	output stage_t           out_stage
);

	localparam bit HAS_BIT = (SHIFT < COORD_W);
	localparam int BIT_IDX = HAS_BIT ? SHIFT : 0;

	logic [OFF_W-1:0] rem_hi;
	logic [OFF_W-1:0] rem_sub;
	logic [TOT_W-1:0] acc_add;
	logic             fits;
	stage_t           nxt;
	logic             vld_s1;
	stage_t           step_s1;

	// Comparing the shifted-down remainder keeps the divisor test 32 bits wide.
	// Only the low coordinate bits of a quotient are kept; the high ones of
	// dimension 0 only shape the remainder.
	always_comb begin
		rem_hi  = in_stage.rem >> SHIFT;
		fits    = (rem_hi >= divisor);
		rem_sub = in_stage.rem - (divisor << SHIFT);
		acc_add = in_stage.acc + (TOT_W'(divisor) << BIT_IDX);
		nxt     = in_stage;
		if (in_stage.delin) begin
			if (fits) begin
				nxt.rem = rem_sub;
				if (HAS_BIT) begin
					nxt.coord[DIM][BIT_IDX] = 1'b1;
				end
			end
		end else if (HAS_BIT && in_stage.coord[DIM][BIT_IDX]) begin
			nxt.acc = acc_add;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1 <= nxt;
		end
	end

	assign out_vld   = vld_s1;
	assign out_stage = step_s1;

endmodule

// ----- design/tidx_out_buf.sv -----
// Result formatting, output register and skid stage.
`timescale 1ns / 1ps

module tidx_out_buf import tidx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tail_vld,
	input  stage_t           tail,
	input  logic [TOT_W-1:0] total,
	input  logic             out_ready,
	output logic             out_vld,
	output rsp_t             res,
	output logic             stall
);

	logic [TOT_W-1:0] sum;
	rsp_t             fin;
	logic             out_free;
	logic             out_vld_q;
	logic             skid_vld_q;
	rsp_t             out_q;
	rsp_t             skid_q;

	always_comb begin
		sum = tail.acc + TOT_W'(tail.coord[NDIM-1]);
		fin = '0;
		if (tail.delin) begin
			for (int j = 0; j < NDIM - 1; j++) begin
				fin.coord[j] = mask_coord(tail.coord[j]);
			end
			fin.coord[NDIM-1] = mask_coord(tail.rem[COORD_W-1:0]);
			fin.oor           = tail.oor;
		end else begin
			fin.oor    = (sum >= total);
			fin.offset = sum[OFF_W] ? {OFF_W{1'b1}} : sum[OFF_W-1:0];
		end
	end

	assign out_free = !out_vld_q || out_ready;

	// The chain only advances while the skid stage is empty, so a word at the
	// tail is consumed exactly when stall is low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= tail_vld;
			end
		end else if (!skid_vld_q && tail_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else begin
				out_q <= fin;
			end
		end else if (!skid_vld_q) begin
			skid_q <= fin;
		end
	end

	assign out_vld = out_vld_q;
	assign res     = out_q;
	assign stall   = skid_vld_q;

endmodule

// ----- design/tidx_checker.sv -----
// Port-level assertions for the tensor index linearizer, bound to the top level.
`timescale 1ns / 1ps

module tidx_checker import tidx_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [OFF_W-1:0]     offset_out,
	input logic [COORD_W-1:0]   coord0_out,
	input logic [COORD_W-1:0]   coord1_out,
	input logic [COORD_W-1:0]   coord2_out,
	input logic [COORD_W-1:0]   coord3_out,
	input logic                 out_of_range,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index
);

	// Words in flight: entry stage, chain cells, output register and skid stage.
	logic [5:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 6'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 6'd1;
		end
	end

	// A result word never shows up without a request word behind it.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result word without an outstanding request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({offset_out, coord0_out, coord1_out, coord2_out, coord3_out,
				out_of_range}))
		else $error("stalled result word changed");

	// The stride rebuild after a write to a used register blocks requests while it runs.
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index <= REG_DIM3) |=>
			!in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("request taken while strides were being rebuilt");

	// Only a linearize result carries an offset, and it never carries coordinates.
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (offset_out != '0) |->
			(coord0_out == '0) && (coord1_out == '0) &&
			(coord2_out == '0) && (coord3_out == '0))
		else $error("result word mixes an offset with coordinates");

endmodule

bind tensor_index_linearizer tidx_checker u_tidx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.offset_out   (rsp.offset_out),
	.coord0_out   (rsp.coord0_out),
	.coord1_out   (rsp.coord1_out),
	.coord2_out   (rsp.coord2_out),
	.coord3_out   (rsp.coord3_out),
	.out_of_range (rsp.out_of_range),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index)
);

// ----- tb/sv/tidx_result_checker.sv -----
// Result checker for the tensor index linearizer: tracks the shape, predicts and compares words.
`timescale 1ns / 1ps

module tidx_result_checker import tidx_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	tidx_req_if                   req,
	tidx_rsp_if                   rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           mismatches,
	output int unsigned           outstanding
);

	logic [RANK_W-1:0] shape_rank;
	logic [DIM_W-1:0]  extent [NDIM];
	logic [OFF_W-1:0]  stride [NDIM-1];
	logic [TOT_W-1:0]  elem_count;

	rsp_t        expected_results [$];
	rsp_t        want;
	int unsigned fail_count;

	function automatic int unsigned used_rank();
		int unsigned r;
		r = shape_rank;
		if (r < 1) r = 1;
		if (r > RANK_LIM) r = RANK_LIM;
		return r;
	endfunction

	function automatic longint unsigned used_extent(input int unsigned i);
		longint unsigned d;
		d = extent[i];
		if (d < 1) d = 1;
		if (d > DIM_MAX) d = DIM_MAX;
		return d;
	endfunction

	// Strides are products of the extents inside each dimension; unused ones stay at 1.
	function automatic void rebuild_shape();
		longint unsigned acc;
		int unsigned     n;
		int              i;
		n = used_rank();
		acc = 1;
		for (i = 0; i < NDIM - 1; i++) stride[i] = 1;
		for (i = n; i > 0; i--) begin
			if (i - 1 < NDIM - 1) stride[i-1] = OFF_W'(acc);
			acc = acc * used_extent(i - 1);
		end
		elem_count = TOT_W'(acc);
	endfunction

	function automatic void write_shape(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_RANK: shape_rank = data[RANK_W-1:0];
			REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3: extent[idx - REG_DIM0] = data;
			default: return;
		endcase
		rebuild_shape();
	endfunction

	function automatic rsp_t convert_index(input logic kind,
			input logic [NDIM-1:0][COORD_W-1:0] coords, input logic [OFF_W-1:0] off);
		rsp_t            r;
		longint unsigned sum;
		longint unsigned rem;
		int unsigned     n;
		int              i;
		r = '0;
		n = used_rank();
		if (kind == REQ_LIN) begin
			sum = 0;
			for (i = 0; i + 1 < n; i++)
				sum = sum + longint'(coords[i] & COORD_MASK) * stride[i];
			sum = sum + (coords[n-1] & COORD_MASK);
			r.oor = (sum >= elem_count);
			r.offset = (sum > 64'hFFFF_FFFF) ? '1 : OFF_W'(sum);
		end else begin
			rem = off;
			r.oor = (rem >= elem_count);
			for (i = 0; i + 1 < n; i++) begin
				r.coord[i] = COORD_W'(rem / stride[i]) & COORD_MASK;
				rem = rem % stride[i];
			end
			r.coord[n-1] = COORD_W'(rem) & COORD_MASK;
		end
		return r;
	endfunction

	function automatic void compare_field(input string name, input longint unsigned exp_val,
			input longint unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_rank = 1;
			for (int i = 0; i < NDIM; i++) extent[i] = 1;
			rebuild_shape();
			expected_results.delete();
			fail_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("result word arrived with no request waiting: offset_out 0x%0h",
						rsp.offset_out);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("offset_out", want.offset, rsp.offset_out);
					compare_field("coord0_out", want.coord[0], rsp.coord0_out);
					compare_field("coord1_out", want.coord[1], rsp.coord1_out);
					compare_field("coord2_out", want.coord[2], rsp.coord2_out);
					compare_field("coord3_out", want.coord[3], rsp.coord3_out);
					compare_field("out_of_range", want.oor, rsp.out_of_range);
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(convert_index(req.req_type,
					{req.coord3_in, req.coord2_in, req.coord1_in, req.coord0_in},
					req.offset_in));
			if (cfg_we) write_shape(cfg_index, cfg_data);
			mismatches <= fail_count;
			outstanding <= expected_results.size();
		end
	end

endmodule

// ----- tb/sv/tensor_index_linearizer_test.sv -----
// Testbench top for the tensor index linearizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tensor_index_linearizer_test;
	import tidx_pkg::*;

	localparam int JUNK_W = CFG_DATA_W - RANK_W;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           mismatches;
	int unsigned           outstanding;

	int unsigned gap_pct = 25;
	int unsigned stall_pct = 25;
	int unsigned lin_count = 0;
	int unsigned delin_count = 0;
	int unsigned shape_count = 0;

	// Effective shape, used only to aim the random words at the tensor.
	int unsigned     cur_rank = 1;
	int unsigned     cur_ext [NDIM] = '{1, 1, 1, 1};
	longint unsigned cur_total = 1;

	tidx_req_if req ();
	tidx_rsp_if rsp ();

	tensor_index_linearizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tidx_result_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// The receiver stalls in random bursts while stall_pct is nonzero.
	initial begin
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(1, 100) <= stall_pct) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	function automatic logic [NDIM-1:0][COORD_W-1:0] any_coords();
		logic [NDIM-1:0][COORD_W-1:0] c;
		for (int i = 0; i < NDIM; i++) c[i] = COORD_W'($urandom);
		return c;
	endfunction

	function automatic logic [RANK_W-1:0] pick_rank();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return RANK_W'($urandom_range(MAX_RANK + 1, (1 << RANK_W) - 1));
			default: return RANK_W'($urandom_range(1, MAX_RANK));
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_extent();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DIM_W'($urandom_range(DIM_MAX + 1, (1 << DIM_W) - 1));
			2: return DIM_MAX;
			3: return DIM_W'(1);
			4, 5: return DIM_W'($urandom_range(2, 8));
			default: return DIM_W'($urandom_range(1, DIM_MAX));
		endcase
	endfunction

	task automatic push_request(input req_kind_t kind, input logic [NDIM-1:0][COORD_W-1:0] c,
			input logic [OFF_W-1:0] off);
		if ($urandom_range(1, 100) <= gap_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.req_type  <= kind;
		req.coord0_in <= c[0];
		req.coord1_in <= c[1];
		req.coord2_in <= c[2];
		req.coord3_in <= c[3];
		req.offset_in <= off;
		do @(posedge clk); while (!req.ready);
		if (kind == REQ_LIN) lin_count++;
		else delin_count++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Writes every register back to back, sometimes followed by a write to an unused index.
	task automatic apply_shape(input logic [RANK_W-1:0] r,
			input logic [NDIM-1:0][DIM_W-1:0] ext);
		logic [JUNK_W-1:0] junk;
		int unsigned       d;
		for (int i = 0; i <= NDIM; i++) begin
			cfg_we <= 1'b1;
			if (i == 0) begin
				junk = JUNK_W'($urandom);
				cfg_index <= REG_RANK;
				cfg_data  <= {junk, r};
			end else begin
				cfg_index <= CFG_IDX_W'(REG_DIM0 + i - 1);
				cfg_data  <= ext[i-1];
			end
			@(posedge clk);
		end
		if ($urandom_range(0, 3) == 0) begin
			cfg_index <= CFG_IDX_W'($urandom_range(REG_DIM3 + 1, (1 << CFG_IDX_W) - 1));
			cfg_data  <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_rank = (r < 1) ? 1 : (r > RANK_LIM) ? RANK_LIM : r;
		cur_total = 1;
		for (int i = 0; i < NDIM; i++) begin
			d = ext[i];
			cur_ext[i] = (d < 1) ? 1 : (d > DIM_MAX) ? DIM_MAX : d;
			if (i < cur_rank) cur_total = cur_total * cur_ext[i];
		end
		shape_count++;
	endtask

	initial begin
		logic [NDIM-1:0][COORD_W-1:0] c;
		logic [OFF_W-1:0]             off;
		req_kind_t                    kind;

		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_RANK;
		cfg_data      <= '0;
		req.valid     <= 1'b0;
		req.req_type  <= REQ_LIN;
		req.coord0_in <= '0;
		req.coord1_in <= '0;
		req.coord2_in <= '0;
		req.coord3_in <= '0;
		req.offset_in <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset shape is a single dimension of extent one.
		push_request(REQ_LIN, '0, OFF_W'($urandom));
		push_request(REQ_LIN, '1, '1);
		push_request(REQ_DELIN, '1, '0);
		push_request(REQ_DELIN, '0, '1);
		drain();

		// Largest tensor: the last offset of a 32-bit space is still inside it.
		apply_shape(RANK_LIM, {NDIM{DIM_MAX}});
		push_request(REQ_LIN, '1, '0);
		push_request(REQ_LIN, '0, '1);
		push_request(REQ_DELIN, any_coords(), '1);
		push_request(REQ_DELIN, any_coords(), 32'h0102_0304);
		push_request(REQ_DELIN, any_coords(), '0);
		drain();

		// Rank above the maximum and extents of zero and above the limit are clamped.
		apply_shape('1, {DIM_W'(3), DIM_W'(DIM_MAX + 1), {DIM_W{1'b1}}, DIM_W'(0)});
		push_request(REQ_LIN, '1, OFF_W'($urandom));
		push_request(REQ_DELIN, any_coords(), '1);
		push_request(REQ_DELIN, any_coords(), OFF_W'(cur_total - 1));
		push_request(REQ_DELIN, any_coords(), OFF_W'(cur_total));
		drain();

		// Rank zero acts as one, and coordinates past the rank are ignored.
		apply_shape('0, {DIM_W'(9), DIM_W'(2), DIM_W'(4), DIM_W'(5)});
		push_request(REQ_LIN, {COORD_W'(255), COORD_W'(255), COORD_W'(255), COORD_W'(4)}, '0);
		push_request(REQ_LIN, {COORD_W'(255), COORD_W'(255), COORD_W'(255), COORD_W'(5)}, '0);
		push_request(REQ_DELIN, '1, OFF_W'(4));
		drain();

		// Two dimensions: an out-of-range offset keeps only the low bits of the outer coordinate.
		apply_shape(RANK_W'(2), {DIM_W'(1), DIM_W'(1), DIM_W'(7), DIM_W'(3)});
		push_request(REQ_DELIN, any_coords(), '1);
		push_request(REQ_LIN, {COORD_W'(0), COORD_W'(0), COORD_W'(6), COORD_W'(2)}, '1);

		for (int phase = 0; phase < 20; phase++) begin
			drain();
			apply_shape(pick_rank(), {pick_extent(), pick_extent(), pick_extent(), pick_extent()});
			if (phase >= 17 || phase % 5 == 2) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = $urandom_range(10, 50);
				stall_pct = $urandom_range(10, 50);
			end
			repeat (80) begin
				kind = ($urandom_range(0, 1) == 0) ? REQ_LIN : REQ_DELIN;
				c = any_coords();
				off = OFF_W'($urandom);
				if (kind == REQ_LIN) begin
					for (int i = 0; i < cur_rank; i++)
						if ($urandom_range(0, 9) < 8)
							c[i] = COORD_W'($urandom_range(0, cur_ext[i] - 1));
				end else begin
					case ($urandom_range(0, 9))
						7: off = OFF_W'(cur_total + $urandom_range(0, 2) - 1);
						8, 9: ;
						default: off = OFF_W'($urandom_range(0, OFF_W'(cur_total - 1)));
					endcase
				end
				push_request(kind, c, off);
			end
		end

		drain();
		repeat (60) @(posedge clk);
		$display("Checked %0d linearize and %0d delinearize words over %0d tensor shapes,",
			lin_count, delin_count, shape_count);
		$display("including clamped ranks and extents, out-of-range offsets and a 2^32 tensor.");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
